### rtl/asvt_pkg.sv
// Package: widths, register indexes and reset values of the alpha-sphere vertex test.
`timescale 1ns / 1ps
package asvt_pkg;
  localparam int unsigned CoordW = 28;
  localparam int unsigned SumW   = 30;
  localparam int unsigned TolW   = 16;
  localparam int unsigned EnegW  = 10;
  localparam int unsigned CntW   = 3;
  localparam int unsigned SlotW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NeighboursDef = 4;
  // squared distance width and root width; three squares of up to 29-bit
  // magnitudes need 60 bits, already an even count for the root unit
  localparam int unsigned SqW   = 60;
  localparam int unsigned RootW = 30;

  localparam logic [CfgIdxW-1:0] RegMinRadius = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRadius = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTolerance = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinApolar = 3'd3;
  localparam logic [CfgIdxW-1:0] RegShiftX    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShiftY    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegShiftZ    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegApolarThr = 3'd7;

  localparam logic [CoordW-1:0] MinRadiusRst = 28'd222822;
  localparam logic [CoordW-1:0] MaxRadiusRst = 28'd406323;
  localparam logic [TolW-1:0]   TolRst       = 16'd66;
  localparam logic [CntW-1:0]   MinApolarRst = 3'd3;
  localparam logic [EnegW-1:0]  ApolarThrRst = 10'd717;

  typedef struct packed {
    logic [CoordW-1:0] min_radius;
    logic [CoordW-1:0] max_radius;
    logic [TolW-1:0]   tolerance;
    logic [CntW-1:0]   min_apolar;
    logic [CoordW-1:0] shift_x;
    logic [CoordW-1:0] shift_y;
    logic [CoordW-1:0] shift_z;
    logic [EnegW-1:0]  apolar_thr;
  } cfg_t;
endpackage

### rtl/asvt_sqsum.sv
// Squared distance: three components squared by a bit-serial shift-add multiplier.
`timescale 1ns / 1ps
module asvt_sqsum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [asvt_pkg::SumW-1:0]  dx_i,
  input  logic [asvt_pkg::SumW-1:0]  dy_i,
  input  logic [asvt_pkg::SumW-1:0]  dz_i,
  output logic                       done_o,
  output logic [asvt_pkg::SqW-1:0]   sq_o
);
  import asvt_pkg::*;
  localparam int unsigned MagW = SumW - 1;
  localparam int unsigned CntBits = $clog2(MagW + 1);

  logic [MagW-1:0] mx_q, my_q, mz_q, sx_d, sy_d, sz_d;
  logic [SqW-1:0]  ax_q, ay_q, az_q, acc_q;
  logic [CntBits-1:0] cnt_q;
  logic busy_q, fin_q;

  function automatic logic [MagW-1:0] mag(input logic [SumW-1:0] v);
    logic [SumW-1:0] n;
    n = v[SumW-1] ? (~v + 1'b1) : v;
    return n[MagW-1:0];
  endfunction

  // one multiplier bit per cycle for each axis; the right-shifted operand is the multiplier
  assign sx_d = mx_q >> 1;
  assign sy_d = my_q >> 1;
  assign sz_d = mz_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntBits'(MagW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // multiplicands move up one bit per cycle
  logic [SqW-1:0] px, py, pz;
  assign px = mx_q[0] ? ax_q : '0;
  assign py = my_q[0] ? ay_q : '0;
  assign pz = mz_q[0] ? az_q : '0;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q <= mag(dx_i);
      my_q <= mag(dy_i);
      mz_q <= mag(dz_i);
      ax_q <= SqW'(mag(dx_i));
      ay_q <= SqW'(mag(dy_i));
      az_q <= SqW'(mag(dz_i));
      acc_q <= '0;
    end else if (busy_q) begin
      mx_q <= sx_d;
      my_q <= sy_d;
      mz_q <= sz_d;
      ax_q <= ax_q << 1;
      ay_q <= ay_q << 1;
      az_q <= az_q << 1;
      acc_q <= acc_q + px + py + pz;
    end
  end

  assign done_o = fin_q;
  assign sq_o   = acc_q;
endmodule

### rtl/asvt_isqrt.sv
// Integer square root, two radicand bits per cycle (restoring digit recurrence).
`timescale 1ns / 1ps
module asvt_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [asvt_pkg::SqW-1:0]   rad_i,
  output logic                       done_o,
  output logic [asvt_pkg::RootW-1:0] root_o
);
  import asvt_pkg::*;
  localparam int unsigned CntBits = $clog2(RootW + 1);

  logic [SqW-1:0]     rad_q;
  logic [RootW+1:0]   rem_q, trial, rem_d;
  logic [RootW-1:0]   root_q;
  logic [CntBits-1:0] cnt_q;
  logic busy_q, fin_q;

  always_comb begin
    rem_d = {rem_q[RootW-1:0], rad_q[SqW-1 -: 2]};
    trial = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntBits'(RootW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_d >= trial) begin
        rem_q  <= rem_d - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_d;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = fin_q;
  assign root_o = root_q;
endmodule

### rtl/alpha_sphere_vertex_test_top.sv
// Top level: accepts four atom items per vertex, checks the sphere and emits one result.
// Each accepted item passes the serial square, the serial root and the update step in that order.
// A new item is taken only after the previous one has finished its update step.
// The last-slot result is held in an output register; the next item is taken while it waits.
// A last-slot update waits while the previous result is still held.
// Reset (rst_ni low, asynchronous) restores register defaults and clears accumulators.
`timescale 1ns / 1ps
module alpha_sphere_vertex_test_top #(
  parameter int unsigned NEIGHBOURS = asvt_pkg::NeighboursDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: vertex_x, vertex_y, vertex_z, atom_x, atom_y, atom_z, atom_electroneg, neighbor_slot
  input  logic [183:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: accepted, radius, is_apolar, bary_x, bary_y, bary_z
  output logic [119:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [asvt_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [asvt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);
  import asvt_pkg::*;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NEIGHBOURS - 1);
  localparam logic [CoordW-1:0] RadMax = {CoordW{1'b1}};

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StSq = 4'b0010, StRoot = 4'b0100, StUpd = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cfg_t cfg_q;
  logic [CoordW-1:0] first_q;
  logic all_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] sx_q, sy_q, sz_q;
  logic [CoordW-1:0] ax_q, ay_q, az_q;
  logic apo_q;
  logic [SlotW-1:0] slot_q;
  logic [SumW-1:0] dx_q, dy_q, dz_q;
  logic [119:0] out_q;
  logic ovalid_q;

  // configuration port
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{MinRadiusRst, MaxRadiusRst, TolRst, MinApolarRst, '0, '0, '0, ApolarThrRst};
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegMinRadius: cfg_q.min_radius <= cfg_data_i;
        RegMaxRadius: cfg_q.max_radius <= cfg_data_i;
        RegTolerance: cfg_q.tolerance  <= cfg_data_i[TolW-1:0];
        RegMinApolar: cfg_q.min_apolar <= cfg_data_i[CntW-1:0];
        RegShiftX:    cfg_q.shift_x    <= cfg_data_i;
        RegShiftY:    cfg_q.shift_y    <= cfg_data_i;
        RegShiftZ:    cfg_q.shift_z    <= cfg_data_i;
        RegApolarThr: cfg_q.apolar_thr <= cfg_data_i[EnegW-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [CoordW-1:0] vx, vy, vz, ax, ay, az;
  logic [EnegW-1:0] en;
  logic [SlotW-1:0] sl;
  assign {sl, en, az, ay, ax, vz, vy, vx} = s_axis_tdata[179:0];

  logic take;
  assign s_axis_tready = (state_q == StIdle);
  assign take = s_axis_tvalid && s_axis_tready;

  // update step; the last slot waits until the output register is free
  logic upd_go;
  assign upd_go = (state_q == StUpd) &&
                  !((slot_q == LastSlot) && ovalid_q && !m_axis_tready);

  function automatic logic [SumW-1:0] sx30(input logic [CoordW-1:0] v);
    return {{(SumW-CoordW){v[CoordW-1]}}, v};
  endfunction

  // distance units
  logic sq_done, rt_done;
  logic [SqW-1:0] sq;
  logic [RootW-1:0] root;
  asvt_sqsum u_sq (.clk_i, .rst_ni, .start_i(take), .dx_i(sx30(vx) - sx30(cfg_q.shift_x) - sx30(ax)),
    .dy_i(sx30(vy) - sx30(cfg_q.shift_y) - sx30(ay)),
    .dz_i(sx30(vz) - sx30(cfg_q.shift_z) - sx30(az)), .done_o(sq_done), .sq_o(sq));
  asvt_isqrt u_rt (.clk_i, .rst_ni, .start_i(sq_done), .rad_i(sq), .done_o(rt_done),
    .root_o(root));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (take) state_d = StSq;
      StSq:   if (sq_done) state_d = StRoot;
      StRoot: if (rt_done) state_d = StUpd;
      StUpd:  if (upd_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // update of vertex state with saturated distance
  logic [CoordW-1:0] d;
  logic [CoordW:0] d_tol, max_tol, diff;
  logic ok0, oki, all_n;
  logic [CntW-1:0] cnt_n;
  logic [SumW-1:0] nsx, nsy, nsz;
  always_comb begin
    d = (|root[RootW-1:CoordW]) ? RadMax : root[CoordW-1:0];
    d_tol = {1'b0, d} + (CoordW+1)'(cfg_q.tolerance);
    max_tol = {1'b0, cfg_q.max_radius} + (CoordW+1)'(cfg_q.tolerance);
    ok0 = ({1'b0, cfg_q.min_radius} <= d_tol) && ({1'b0, d} <= max_tol) && (d != '0);
    diff = (first_q > d) ? {1'b0, first_q - d} : {1'b0, d - first_q};
    oki = diff < (CoordW+1)'(cfg_q.tolerance);
    all_n = (slot_q == '0) ? ok0 : (all_q && oki);
    cnt_n = (slot_q == '0) ? '0 : cnt_q;
    if (apo_q && cnt_n != {CntW{1'b1}}) cnt_n = cnt_n + 1'b1;
    nsx = ((slot_q == '0) ? '0 : sx_q) + sx30(ax_q);
    nsy = ((slot_q == '0) ? '0 : sy_q) + sx30(ay_q);
    nsz = ((slot_q == '0) ? '0 : sz_q) + sx30(az_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      first_q <= '0;
      all_q <= 1'b1;
      cnt_q <= '0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= (ovalid_q && !m_axis_tready) || (upd_go && slot_q == LastSlot);
      if (upd_go) begin
        all_q <= all_n;
        cnt_q <= cnt_n;
        sx_q <= nsx; sy_q <= nsy; sz_q <= nsz;
        if (slot_q == '0) first_q <= d;
      end
    end
  end

  logic [CoordW-1:0] fr;
  assign fr = (slot_q == '0) ? d : first_q;
  always_ff @(posedge clk_i) begin
    if (take) begin
      ax_q <= ax; ay_q <= ay; az_q <= az;
      apo_q <= en < cfg_q.apolar_thr;
      slot_q <= sl;
    end
    if (upd_go && slot_q == LastSlot) begin
      out_q <= all_n ? {6'd0, nsz[SumW-1:2], nsy[SumW-1:2], nsx[SumW-1:2],
                        cnt_n >= cfg_q.min_apolar, fr, 1'b1} : '0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule

### rtl/asvt_checker.sv
// Port-level checker for the alpha-sphere vertex test, bound to the top level.
`timescale 1ns / 1ps
module asvt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  // rejected result carries zero fields
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[113:1] == '0) else $error("reject nonzero");
  // an item is never taken right after another
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back take");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind alpha_sphere_vertex_test_top asvt_checker u_chk (.clk_i, .rst_ni, .s_axis_tvalid,
  .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

### tb/sv/tb.sv
// Testbench for the alpha-sphere vertex test: directed and random vertices checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import asvt_pkg::*;

  typedef struct packed {
    logic [1:0]  slot;
    logic [9:0]  eneg;
    logic [27:0] az;
    logic [27:0] ay;
    logic [27:0] ax;
    logic [27:0] vz;
    logic [27:0] vy;
    logic [27:0] vx;
  } atom_item_t;

  // first member is the most significant: accepted sits in bit 0
  typedef struct packed {
    logic [27:0] bary_z;
    logic [27:0] bary_y;
    logic [27:0] bary_x;
    logic        is_apolar;
    logic [27:0] radius;
    logic        accepted;
  } sphere_res_t;

  localparam int DrainCycles = 100;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [183:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;

  alpha_sphere_vertex_test_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_addr_i, .cfg_data_i, .cfg_valid_i, .cfg_ready_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow configuration
  logic [27:0] min_rad, max_rad, shx, shy, shz;
  logic [15:0] tol;
  logic [2:0]  min_apolar;
  logic [9:0]  apolar_thr;
  // predicted vertex state
  logic [27:0] first_dist;
  logic        on_sphere;
  logic [2:0]  apolar_cnt;
  logic [29:0] sum_x, sum_y, sum_z;

  sphere_res_t spheres_q[$];
  int  errors = 0;
  bit  no_idle = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_dist(logic [27:0] v, logic [27:0] s, logic [27:0] a);
    longint d;
    d = longint'($signed(v)) - longint'($signed(s)) - longint'($signed(a));
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  // update vertex state for one atom, push a result on slot 3
  task automatic predict_sphere(atom_item_t it);
    longint unsigned d, diff;
    sphere_res_t r;
    d = isqrt(sq_dist(it.vx, shx, it.ax) + sq_dist(it.vy, shy, it.ay)
              + sq_dist(it.vz, shz, it.az));
    if (d > 64'h0FFF_FFFF) d = 64'h0FFF_FFFF;
    if (it.slot == 2'd0) begin
      on_sphere = 1'b1;
      apolar_cnt = '0;
      sum_x = '0; sum_y = '0; sum_z = '0;
      first_dist = d[27:0];
      if (!(longint'(min_rad) <= d + tol && d <= longint'(max_rad) + tol) || d == 0)
        on_sphere = 1'b0;
    end else begin
      diff = (first_dist > d) ? first_dist - d : d - first_dist;
      if (!(diff < tol)) on_sphere = 1'b0;
    end
    if (it.eneg < apolar_thr && apolar_cnt < 3'd7) apolar_cnt++;
    sum_x += {{2{it.ax[27]}}, it.ax};
    sum_y += {{2{it.ay[27]}}, it.ay};
    sum_z += {{2{it.az[27]}}, it.az};
    if (it.slot == 2'd3) begin
      r = '0;
      if (on_sphere) begin
        r.accepted = 1'b1;
        r.radius = first_dist;
        r.is_apolar = (apolar_cnt >= min_apolar);
        r.bary_x = sum_x[29:2];
        r.bary_y = sum_y[29:2];
        r.bary_z = sum_z[29:2];
      end
      spheres_q.push_back(r);
    end
  endtask

  // send one item; valid stays high when the next item follows with no gap
  task automatic send_atom(atom_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {4'd0, it};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sphere(it);
  endtask

  // wait for all results, then let any slot 0..2 work finish
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (spheres_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [27:0] val);
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMinRadius: min_rad = val;
      RegMaxRadius: max_rad = val;
      RegTolerance: tol = val[15:0];
      RegMinApolar: min_apolar = val[2:0];
      RegShiftX:    shx = val;
      RegShiftY:    shy = val;
      RegShiftZ:    shz = val;
      RegApolarThr: apolar_thr = val[9:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [27:0] mn, logic [27:0] mx, logic [15:0] t, logic [2:0] ma,
                         logic [27:0] sx, logic [27:0] sy, logic [27:0] sz, logic [9:0] thr);
    cfg_write(RegMinRadius, mn);
    cfg_write(RegMaxRadius, mx);
    cfg_write(RegTolerance, {12'd0, t});
    cfg_write(RegMinApolar, {25'd0, ma});
    cfg_write(RegShiftX, sx);
    cfg_write(RegShiftY, sy);
    cfg_write(RegShiftZ, sz);
    cfg_write(RegApolarThr, {18'd0, thr});
  endtask

  function automatic logic [27:0] pick_center(logic [27:0] s);
    longint c, v;
    c = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
    v = c + longint'($signed(s));
    if (v > 134217727 || v < -134217728) c = -c;
    return c[27:0];
  endfunction

  // four atoms at distance r (+jitter) from vertex-shift along random axes
  task automatic send_vertex(int r, int jit, bit apolar);
    atom_item_t it;
    logic [27:0] cx, cy, cz;
    int off, ax;
    cx = pick_center(shx); cy = pick_center(shy); cz = pick_center(shz);
    it.vx = cx + shx; it.vy = cy + shy; it.vz = cz + shz;
    for (int k = 0; k < 4; k++) begin
      off = r + ((k == 0 || jit == 0) ? 0 : $urandom_range(0, 2 * jit) - jit);
      if ($urandom_range(0, 1)) off = -off;
      ax = $urandom_range(0, 2);
      it.ax = cx + 28'((ax == 0) ? off : 0);
      it.ay = cy + 28'((ax == 1) ? off : 0);
      it.az = cz + 28'((ax == 2) ? off : 0);
      it.eneg = apolar ? 10'($urandom_range(0, 400)) : 10'($urandom_range(0, 1023));
      it.slot = 2'(k);
      send_atom(it);
    end
  endtask

  function automatic atom_item_t noise_atom();
    atom_item_t it;
    it.vx = 28'($urandom); it.vy = 28'($urandom); it.vz = 28'($urandom);
    it.ax = 28'($urandom); it.ay = 28'($urandom); it.az = 28'($urandom);
    it.eneg = 10'($urandom); it.slot = 2'($urandom);
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    sphere_res_t act, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata[113:0];
      if (spheres_q.size() == 0) begin
        $error("unexpected result item %h", act);
        errors++;
      end else begin
        exp_r = spheres_q.pop_front();
        if (act.accepted !== exp_r.accepted) begin
          $error("accepted: expected %0d actual %0d", exp_r.accepted, act.accepted); errors++;
        end
        if (act.radius !== exp_r.radius) begin
          $error("radius: expected %0d actual %0d", exp_r.radius, act.radius); errors++;
        end
        if (act.is_apolar !== exp_r.is_apolar) begin
          $error("is_apolar: expected %0d actual %0d", exp_r.is_apolar, act.is_apolar); errors++;
        end
        if (act.bary_x !== exp_r.bary_x) begin
          $error("bary_x: expected %h actual %h", exp_r.bary_x, act.bary_x); errors++;
        end
        if (act.bary_y !== exp_r.bary_y) begin
          $error("bary_y: expected %h actual %h", exp_r.bary_y, act.bary_y); errors++;
        end
        if (act.bary_z !== exp_r.bary_z) begin
          $error("bary_z: expected %h actual %h", exp_r.bary_z, act.bary_z); errors++;
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // defaults after reset, special cases by hand
  task automatic test_directed;
    atom_item_t it;
    send_vertex(262144, 0, 1);          // accepted, apolar
    send_vertex(262144, 0, 0);
    send_vertex(262144, 200, 0);        // jitter beyond tolerance
    send_vertex(1000, 0, 1);            // below min radius
    send_vertex(500000, 0, 1);          // above max radius
    // zero radius: atom on the vertex
    it = '0; it.eneg = 10'd1023;
    for (int k = 0; k < 4; k++) begin
      it.slot = 2'(k);
      send_atom(it);
    end
    // extreme coordinates, saturated distance, slots without slot 0
    it.vx = 28'h7FF_FFFF; it.vy = 28'h800_0000; it.vz = 28'h7FF_FFFF;
    it.ax = 28'h800_0000; it.ay = 28'h7FF_FFFF; it.az = 28'h800_0000;
    it.eneg = 10'd0;
    it.slot = 2'd0; send_atom(it);
    it.slot = 2'd3; send_atom(it);
    it.slot = 2'd2; send_atom(it);
    it.slot = 2'd2; send_atom(it);
    it.slot = 2'd3; send_atom(it);
    it.slot = 2'd1; send_atom(it);
    drain();
  endtask

  // register extremes
  task automatic test_config;
    cfg_all(28'd0, 28'hFFF_FFFF, 16'hFFFF, 3'd0, 28'h7FF_FFFF, 28'h800_0000, 28'd0, 10'd1023);
    send_vertex(262144, 3000, 0);
    send_vertex(0, 0, 0);
    drain();
    cfg_all(28'd100000, 28'd100000, 16'd0, 3'd4, 28'h800_0000, 28'h7FF_FFFF, 28'd12345,
            10'd0);
    send_vertex(100000, 0, 1);          // zero tolerance rejects
    drain();
    cfg_all(28'd0, 28'hFFF_FFFF, 16'd1, 3'd7, 28'd0, 28'd0, 28'd0, 10'd512);
    send_vertex(300000, 0, 1);          // never apolar
    send_vertex(300000, 1, 0);
    drain();
    cfg_all(28'd0, 28'hFFF_FFFF, 16'd50, 3'd2, 28'd0, 28'd0, 28'd0, 10'd512);
    no_idle = 1;
    send_vertex(200000, 60, 1);
    send_vertex(200000, 0, 0);
    drain();
    no_idle = 0;
  endtask

  // random phases: mostly well-formed vertices, some fragments and noise
  task automatic test_random;
    int sent, sel, len, mn, mx;
    atom_item_t it;
    for (int ph = 0; ph < 6; ph++) begin
      mn = $urandom_range(0, 400000);
      mx = mn + $urandom_range(0, 300000);
      cfg_all(28'(mn), 28'(mx),
              16'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200)),
              3'($urandom_range(0, 4)), 28'($urandom_range(0, 1 << 27) - (1 << 26)),
              28'($urandom_range(0, 1 << 27) - (1 << 26)),
              28'($urandom_range(0, 1 << 27) - (1 << 26)), 10'($urandom));
      no_idle = (ph == 2);
      sent = 0;
      while (sent < 265) begin
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          send_vertex($urandom_range((mn > 300) ? mn - 300 : 0, mx + 300),
                      $urandom_range(0, 1) ? 0 : $urandom_range(0, 150),
                      $urandom_range(0, 1));
          sent += 4;
        end else if (sel == 8) begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            it = noise_atom();
            send_atom(it);
          end
          sent += len;
        end else begin
          it = noise_atom();
          send_atom(it);
          sent++;
        end
      end
      drain();
    end
    no_idle = 0;
  endtask

  initial begin
    min_rad = MinRadiusRst; max_rad = MaxRadiusRst; tol = TolRst;
    min_apolar = MinApolarRst; apolar_thr = ApolarThrRst;
    shx = '0; shy = '0; shz = '0;
    first_dist = '0; on_sphere = 1'b1; apolar_cnt = '0;
    sum_x = '0; sum_y = '0; sum_z = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_random();
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

### alpha_sphere_vertex_test_top.f
rtl/asvt_pkg.sv
rtl/asvt_sqsum.sv
rtl/asvt_isqrt.sv
rtl/alpha_sphere_vertex_test_top.sv
rtl/asvt_checker.sv
tb/sv/tb.sv
